FILE: sv/psl_pkg.sv
// Shared types, opcodes, register indexes and lookup functions
// for the pulse sweep and length unit. No dependencies.
package psl_pkg;

   localparam int PERIOD_W = 12;
   localparam int LENGTH_W = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 3;

   localparam logic [PERIOD_W-1:0] MUTE_LIMIT = 12'h7FF;
   localparam logic [PERIOD_W-1:0] CHANGE_LIMIT = 12'h7FF;
   localparam logic [PERIOD_W-1:0] MIN_PERIOD = 12'd8;

   typedef enum logic [2:0] {
      OP_WRITE_PERIOD = 3'd0,
      OP_TRACK        = 3'd1,
      OP_HALF_FRAME   = 3'd2,
      OP_LOAD_LENGTH  = 3'd3,
      OP_ARM_RELOAD   = 3'd4
   } psl_opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SWEEP_ENABLE    = 3'd0,
      CSR_SWEEP_NEGATE    = 3'd1,
      CSR_SWEEP_SHIFT     = 3'd2,
      CSR_DIVIDER_PERIOD  = 3'd3,
      CSR_IS_CHANNEL_ONE  = 3'd4,
      CSR_LENGTH_HALT     = 3'd5
   } psl_csr_index_type;

   typedef struct packed {
      logic       sweep_enable;
      logic       sweep_negate;
      logic [2:0] sweep_shift;
      logic [2:0] sweep_divider_period;
      logic       is_channel_one;
      logic       length_halt;
   } psl_cfg_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [10:0] period_value;
      logic [4:0]  length_index;
      logic        channel_enabled;
   } psl_item_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] timer_period;
      logic                muted;
      logic [LENGTH_W-1:0] length_count;
      logic                audible;
   } psl_result_type;

   function automatic logic mute_of(input logic [PERIOD_W-1:0] p);
      return (p < MIN_PERIOD) || (p > MUTE_LIMIT);
   endfunction

   function automatic logic [LENGTH_W-1:0] length_lookup(input logic [4:0] idx);
      logic [LENGTH_W-1:0] v;
      case (idx)
         5'd0:  v = 8'd10;   5'd1:  v = 8'd254;  5'd2:  v = 8'd20;   5'd3:  v = 8'd2;
         5'd4:  v = 8'd40;   5'd5:  v = 8'd4;    5'd6:  v = 8'd80;   5'd7:  v = 8'd6;
         5'd8:  v = 8'd160;  5'd9:  v = 8'd8;    5'd10: v = 8'd60;   5'd11: v = 8'd10;
         5'd12: v = 8'd14;   5'd13: v = 8'd12;   5'd14: v = 8'd26;   5'd15: v = 8'd14;
         5'd16: v = 8'd12;   5'd17: v = 8'd16;   5'd18: v = 8'd24;   5'd19: v = 8'd18;
         5'd20: v = 8'd48;   5'd21: v = 8'd20;   5'd22: v = 8'd96;   5'd23: v = 8'd22;
         5'd24: v = 8'd192;  5'd25: v = 8'd24;   5'd26: v = 8'd72;   5'd27: v = 8'd26;
         5'd28: v = 8'd16;   5'd29: v = 8'd28;   5'd30: v = 8'd32;   default: v = 8'd30;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/psl_csr.sv
// Configuration registers of the pulse sweep and length unit.
// Depends on psl_pkg.
module psl_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [psl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psl_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output psl_pkg::psl_cfg_type          cfg
);
   import psl_pkg::*;

   psl_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SWEEP_ENABLE:   cfg_in.sweep_enable = csr_write_data[0];
            CSR_SWEEP_NEGATE:   cfg_in.sweep_negate = csr_write_data[0];
            CSR_SWEEP_SHIFT:    cfg_in.sweep_shift = csr_write_data;
            CSR_DIVIDER_PERIOD: cfg_in.sweep_divider_period = csr_write_data;
            CSR_IS_CHANNEL_ONE: cfg_in.is_channel_one = csr_write_data[0];
            CSR_LENGTH_HALT:    cfg_in.length_halt = csr_write_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/psl_core.sv
// Channel state (period, sweep, length counter) and its update on each fired item.
// Depends on psl_pkg.
module psl_core (
   input  logic                    clock,
   input  logic                    reset,
   input  psl_pkg::psl_cfg_type    cfg,
   input  logic                    fire,
   input  psl_pkg::psl_item_type   item,
   output psl_pkg::psl_result_type result
);
   import psl_pkg::*;

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] change_ff, change_in;
   logic                mute_ff, mute_in;
   logic [2:0]          divider_ff, divider_in;
   logic                reload_ff, reload_in;
   logic [LENGTH_W-1:0] length_ff, length_in;

   logic [PERIOD_W-1:0] swept_period;
   logic                sweep_move;

   // The move is judged on the state before this half-frame clock.
   assign sweep_move = (divider_ff == 3'd0) && cfg.sweep_enable && (cfg.sweep_shift != 3'd0)
                       && !mute_ff && (period_ff >= MIN_PERIOD) && (change_ff < CHANGE_LIMIT);

   always_comb begin
      if (cfg.sweep_negate) begin
         swept_period = period_ff - change_ff - {{(PERIOD_W-1){1'b0}}, cfg.is_channel_one};
      end else begin
         swept_period = period_ff + change_ff;
      end
   end

   always_comb begin
      period_in  = period_ff;
      change_in  = change_ff;
      mute_in    = mute_ff;
      divider_in = divider_ff;
      reload_in  = reload_ff;
      length_in  = length_ff;
      case (item.opcode)
         OP_WRITE_PERIOD: period_in = {1'b0, item.period_value};
         OP_TRACK: begin
            change_in = period_ff >> cfg.sweep_shift;
            mute_in   = mute_of(period_ff);
         end
         OP_HALF_FRAME: begin
            if (!item.channel_enabled) begin
               length_in = '0;
            end else if ((length_ff != '0) && !cfg.length_halt) begin
               length_in = length_ff - 8'd1;
            end
            if (sweep_move) begin
               period_in = swept_period;
            end
            if ((divider_ff == 3'd0) || reload_ff) begin
               divider_in = cfg.sweep_divider_period;
               reload_in  = 1'b0;
            end else begin
               divider_in = divider_ff - 3'd1;
            end
            mute_in = mute_of(period_in);
         end
         OP_LOAD_LENGTH: length_in = length_lookup(item.length_index);
         OP_ARM_RELOAD:  reload_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= '0;
         change_ff  <= '0;
         mute_ff    <= 1'b0;
         divider_ff <= '0;
         reload_ff  <= 1'b0;
         length_ff  <= '0;
      end else if (fire) begin
         period_ff  <= period_in;
         change_ff  <= change_in;
         mute_ff    <= mute_in;
         divider_ff <= divider_in;
         reload_ff  <= reload_in;
         length_ff  <= length_in;
      end
   end

   always_comb begin
      result.timer_period = period_in;
      result.muted        = mute_in;
      result.length_count = length_in;
      result.audible      = (length_in != '0) && !mute_in && (period_in > MIN_PERIOD);
   end

endmodule

FILE: sv/psl_out_reg.sv
// Result register with valid/stall handshake toward the consumer.
// Depends on psl_pkg.
module psl_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  psl_pkg::psl_result_type result,
   output logic                    ready,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output psl_pkg::psl_result_type rsp_data
);
   import psl_pkg::*;

   logic           valid_ff;
   psl_result_type data_ff;

   // The register can take a new item when it is empty or being drained.
   assign ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: sv/pulse_sweep_and_length_unit.sv
// Pulse sweep and length unit, top level.
// An accepted item passes the input register, then the result register, before its result is valid.
// Throughput: one item per cycle while the consumer does not stall; the state update runs in the
// cycle the item leaves the input register, so a following item sees it at once.
// Reset is synchronous and active high; it clears the channel state, the configuration
// registers and both valid flags. Depends on psl_pkg, psl_csr, psl_core and psl_out_reg.
module pulse_sweep_and_length_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [2:0]                      req_opcode,
   input  logic [10:0]                     req_period_value,
   input  logic [4:0]                      req_length_index,
   input  logic                            req_channel_enabled,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [psl_pkg::PERIOD_W-1:0]    rsp_timer_period,
   output logic                            rsp_muted,
   output logic [psl_pkg::LENGTH_W-1:0]    rsp_length_count,
   output logic                            rsp_audible,
   input  logic                            csr_write_enable,
   input  logic [psl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psl_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import psl_pkg::*;

   psl_cfg_type    cfg;
   psl_item_type   item_ff;
   logic           item_valid_ff;
   logic           out_ready;
   logic           fire;
   psl_result_type result;
   psl_result_type rsp_data;

   assign fire      = item_valid_ff && out_ready;
   assign req_stall = item_valid_ff && !out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= '{opcode: req_opcode, period_value: req_period_value,
                      length_index: req_length_index, channel_enabled: req_channel_enabled};
      end
   end

   psl_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   psl_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (item_ff),
      .result (result)
   );

   psl_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (item_valid_ff),
      .result    (result),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_timer_period = rsp_data.timer_period;
   assign rsp_muted        = rsp_data.muted;
   assign rsp_length_count = rsp_data.length_count;
   assign rsp_audible      = rsp_data.audible;

endmodule

FILE: sv/psl_checker.sv
// Port-level checks for the pulse sweep and length unit, bound to the top level.
// Depends on psl_pkg and pulse_sweep_and_length_unit.
module psl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [psl_pkg::PERIOD_W-1:0]    rsp_timer_period,
   input logic                            rsp_muted,
   input logic [psl_pkg::LENGTH_W-1:0]    rsp_length_count,
   input logic                            rsp_audible
);
   import psl_pkg::*;

   // A result held by the consumer stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_timer_period)
                                 && $stable(rsp_length_count) && $stable(rsp_audible))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("valid or stall after reset");

   // Audible must agree with the other fields of the same item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_audible == ((rsp_length_count != 8'd0) && !rsp_muted
                                     && (rsp_timer_period > MIN_PERIOD))))
      else $error("audible flag inconsistent");

   // The length table tops out at 254.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_length_count != 8'd255)
      else $error("length count out of range");

   // An item can only be held back while the pipeline is full and the consumer stalls.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without back-pressure");

endmodule

bind pulse_sweep_and_length_unit psl_checker u_psl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_timer_period (rsp_timer_period),
   .rsp_muted        (rsp_muted),
   .rsp_length_count (rsp_length_count),
   .rsp_audible      (rsp_audible)
);
